### design/ltrf_pkg.sv
`default_nettype none

package ltrf_pkg;

  // command codes of an input beat
  localparam logic [1:0] CMD_TX_DONE = 2'd0;
  localparam logic [1:0] CMD_RX_FRAME = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_NOT_DUE = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_UPDATE_PERIOD = 2'd0;
  localparam logic [1:0] CFG_DIVISOR_SHORT = 2'd1;
  localparam logic [1:0] CFG_DIVISOR_MID = 2'd2;
  localparam logic [1:0] CFG_DIVISOR_LONG = 2'd3;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 40;

  localparam logic [39:0] PERIOD_RESET = 40'd1000000000;
  localparam logic [7:0] DIV_SHORT_RESET = 8'd1;
  localparam logic [7:0] DIV_MID_RESET = 8'd10;
  localparam logic [7:0] DIV_LONG_RESET = 8'd60;

  localparam logic [31:0] HDR_BYTES = 32'd14;
  localparam logic [31:0] RATE_SCALE = 32'd1000;

  // rate indexes
  localparam int unsigned NumRates = 5;
  localparam int unsigned RateW = 3;
  localparam logic [2:0] RATE_TX_FRM = 3'd0;
  localparam logic [2:0] RATE_RX_FRM = 3'd1;
  localparam logic [2:0] RATE_TX_BYTE = 3'd2;
  localparam logic [2:0] RATE_RX_BYTE = 3'd3;
  localparam logic [2:0] RATE_LOSS = 3'd4;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### design/ltrf_if.sv
`default_nettype none

interface ltrf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [13:0] frame_length;
  logic        tx_accepted;
  logic [62:0] now_time;

  modport source (output valid, command, frame_length, tx_accepted, now_time, input ready);
  modport sink (input valid, command, frame_length, tx_accepted, now_time, output ready);
endinterface

interface ltrf_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [1:0]         interval_index;
  logic signed [31:0] tx_frm_ema;
  logic signed [31:0] rx_frm_ema;
  logic signed [31:0] tx_byte_ema;
  logic signed [31:0] rx_byte_ema;
  logic signed [31:0] loss_ema;
  logic [31:0]        tx_error_total;
  logic               last;

  modport source (output valid, kind, interval_index, tx_frm_ema, rx_frm_ema,
                  tx_byte_ema, rx_byte_ema, loss_ema, tx_error_total, last,
                  input ready);
  modport sink (input valid, kind, interval_index, tx_frm_ema, rx_frm_ema,
                tx_byte_ema, rx_byte_ema, loss_ema, tx_error_total, last,
                output ready);
endinterface

`default_nettype wire

### design/link_traffic_rate_filter.sv
`default_nettype none
// frame event: the beat goes from S_IDLE to S_EMIT, which registers the result
// update not due: the beat goes through S_IDLE, S_CHK and S_EMIT, which registers the result
// update due: each of the 5*INTERVALS filter steps runs S_RD, S_DIVS, S_DIVW on the shared
//   divider at one quotient bit per cycle; after the loss step of each interval S_REP
//   registers a report, INTERVALS reports per update, the last flagged; a full output holds
//   S_EMIT and S_REP; input ready low while an item runs; async active-low reset clears state, regs to defaults

module link_traffic_rate_filter
  import ltrf_pkg::*;
#(
  parameter int unsigned INTERVALS = 3
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgDataW-1:0]  cfg_wdata_i,
  ltrf_in_if.sink             in_i,
  ltrf_out_if.source          out_o
);

  localparam int unsigned Depth = NumRates * INTERVALS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned IdxW = (INTERVALS > 1) ? $clog2(INTERVALS) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHK  = 7'b0000010,
    S_EMIT = 7'b0000100,
    S_RD   = 7'b0001000,
    S_DIVS = 7'b0010000,
    S_DIVW = 7'b0100000,
    S_REP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [39:0] period_q;
  logic [7:0]  div_short_q, div_mid_q, div_long_q;

  // counters and snapshots
  logic [31:0] tx_frames_q, rx_frames_q, tx_octets_q, rx_octets_q, tx_fail_q;
  logic [31:0] snap_txf_q, snap_rxf_q, snap_txo_q, snap_rxo_q, prev_loss_q;
  logic [63:0] last_time_q;
  logic [62:0] now_q;
  logic [1:0]  kind_q;

  // sequencer
  logic [RateW-1:0] k_q;
  logic [IdxW-1:0]  i_q;
  logic [31:0]      x_q, x_d, sub;
  logic             scale;
  logic [31:0]      y_q, y_cur, y_new;
  logic [31:0]      rep_q [NumRates];

  // filter store
  logic [31:0]      mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [31:0]      rd_q;
  logic             rd_vld_q;
  logic [AddrW-1:0] addr;
  logic             mem_we;

  // output register
  logic        out_vld_q;
  logic [1:0]  o_kind_q, o_idx_q;
  logic [31:0] o_rate_q [NumRates];
  logic [31:0] o_err_q;
  logic        o_last_q;
  logic        slot_free;
  logic        emit_simple, emit_rep;

  logic        in_acc;
  logic        due;
  logic        i_last;
  logic [63:0] elapsed;
  logic [31:0] loss;
  logic [7:0]  dvs_sel;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign slot_free = !out_vld_q || out_o.ready;

  assign elapsed = {1'b0, now_q} - last_time_q;
  assign due = !(elapsed < {24'd0, period_q});
  assign i_last = (i_q == IdxW'(INTERVALS - 1));
  assign loss = tx_frames_q - rx_frames_q;
  assign addr = AddrW'(k_q) * AddrW'(INTERVALS) + AddrW'(i_q);

  // per-period rate for the current rate index
  always_comb begin
    case (k_q)
      RATE_TX_FRM: begin
        sub = tx_frames_q - snap_txf_q;
        scale = 1'b1;
      end
      RATE_RX_FRM: begin
        sub = rx_frames_q - snap_rxf_q;
        scale = 1'b1;
      end
      RATE_TX_BYTE: begin
        sub = tx_octets_q - snap_txo_q;
        scale = 1'b0;
      end
      RATE_RX_BYTE: begin
        sub = rx_octets_q - snap_rxo_q;
        scale = 1'b0;
      end
      default: begin
        sub = loss - prev_loss_q;
        scale = 1'b1;
      end
    endcase
    x_d = scale ? 32'(sub * RATE_SCALE) : sub;
  end

  always_comb begin
    if (i_q == IdxW'(0)) begin
      dvs_sel = div_short_q;
    end else if (i_q == IdxW'(1)) begin
      dvs_sel = div_mid_q;
    end else begin
      dvs_sel = div_long_q;
    end
    if (dvs_sel == 8'd0) begin
      dvs_sel = 8'd1;
    end
  end

  assign y_cur = rd_vld_q ? rd_q : 32'd0;
  assign div_req.start = (state_q == S_DIVS);
  assign div_req.dividend = x_q - y_cur;
  assign div_req.divisor = dvs_sel;
  assign y_new = y_q + div_rsp.quotient;
  assign mem_we = (state_q == S_DIVW) && div_rsp.done;

  ltrf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign emit_simple = (state_q == S_EMIT) && slot_free;
  assign emit_rep = (state_q == S_REP) && slot_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.command == CMD_TX_DONE || in_i.command == CMD_RX_FRAME) begin
            state_d = S_EMIT;
          end else if (in_i.command == CMD_UPDATE) begin
            state_d = S_CHK;
          end
        end
      end
      S_CHK:  state_d = due ? S_RD : S_EMIT;
      S_EMIT: if (slot_free) state_d = S_IDLE;
      S_RD:   state_d = S_DIVS;
      S_DIVS: state_d = S_DIVW;
      S_DIVW: begin
        if (div_rsp.done) begin
          state_d = (k_q == RATE_LOSS) ? S_REP : S_RD;
        end
      end
      S_REP: begin
        if (slot_free) begin
          state_d = i_last ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      period_q <= PERIOD_RESET;
      div_short_q <= DIV_SHORT_RESET;
      div_mid_q <= DIV_MID_RESET;
      div_long_q <= DIV_LONG_RESET;
      tx_frames_q <= '0;
      rx_frames_q <= '0;
      tx_octets_q <= '0;
      rx_octets_q <= '0;
      tx_fail_q <= '0;
      snap_txf_q <= '0;
      snap_rxf_q <= '0;
      snap_txo_q <= '0;
      snap_rxo_q <= '0;
      prev_loss_q <= '0;
      last_time_q <= '0;
      kind_q <= KIND_EVENT;
      k_q <= '0;
      i_q <= '0;
      vld_q <= '0;
      rd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_vld_q <= vld_q[addr];

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_UPDATE_PERIOD: period_q <= cfg_wdata_i;
          CFG_DIVISOR_SHORT: div_short_q <= cfg_wdata_i[7:0];
          CFG_DIVISOR_MID:   div_mid_q <= cfg_wdata_i[7:0];
          CFG_DIVISOR_LONG:  div_long_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        kind_q <= KIND_EVENT;
        k_q <= '0;
        i_q <= '0;
        if (in_i.command == CMD_TX_DONE) begin
          if (in_i.tx_accepted) begin
            tx_frames_q <= tx_frames_q + 32'd1;
            tx_octets_q <= tx_octets_q + HDR_BYTES + 32'(in_i.frame_length);
          end else begin
            tx_fail_q <= tx_fail_q + 32'd1;
          end
        end else if (in_i.command == CMD_RX_FRAME) begin
          rx_frames_q <= rx_frames_q + 32'd1;
          rx_octets_q <= rx_octets_q + 32'(in_i.frame_length);
        end
      end

      if (state_q == S_CHK && !due) begin
        kind_q <= KIND_NOT_DUE;
      end

      if (mem_we) begin
        vld_q[addr] <= 1'b1;
        k_q <= (k_q == RATE_LOSS) ? '0 : k_q + RateW'(1);
      end

      if (emit_rep) begin
        if (i_last) begin
          snap_txf_q <= tx_frames_q;
          snap_rxf_q <= rx_frames_q;
          snap_txo_q <= tx_octets_q;
          snap_rxo_q <= rx_octets_q;
          prev_loss_q <= loss;
          last_time_q <= {1'b0, now_q};
        end else begin
          i_q <= i_q + IdxW'(1);
        end
      end

      if (emit_simple || emit_rep) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[addr];
    if (mem_we) begin
      mem_q[addr] <= y_new;
      rep_q[k_q] <= y_new;
    end
    if (in_acc) begin
      now_q <= in_i.now_time;
    end
    if (state_q == S_RD) begin
      x_q <= x_d;
    end
    if (state_q == S_DIVS) begin
      y_q <= y_cur;
    end
    if (emit_simple) begin
      o_kind_q <= kind_q;
      o_idx_q <= '0;
      for (int r = 0; r < NumRates; r++) begin
        o_rate_q[r] <= '0;
      end
      o_err_q <= tx_fail_q;
      o_last_q <= 1'b1;
    end else if (emit_rep) begin
      o_kind_q <= KIND_REPORT;
      o_idx_q <= 2'(i_q);
      for (int r = 0; r < NumRates; r++) begin
        o_rate_q[r] <= rep_q[r];
      end
      o_err_q <= tx_fail_q;
      o_last_q <= i_last;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.kind = o_kind_q;
  assign out_o.interval_index = o_idx_q;
  assign out_o.tx_frm_ema = $signed(o_rate_q[RATE_TX_FRM]);
  assign out_o.rx_frm_ema = $signed(o_rate_q[RATE_RX_FRM]);
  assign out_o.tx_byte_ema = $signed(o_rate_q[RATE_TX_BYTE]);
  assign out_o.rx_byte_ema = $signed(o_rate_q[RATE_RX_BYTE]);
  assign out_o.loss_ema = $signed(o_rate_q[RATE_LOSS]);
  assign out_o.tx_error_total = o_err_q;
  assign out_o.last = o_last_q;

`ifndef ASSERT_OFF
  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_divw_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVW) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");

  a_counters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> ($stable(tx_frames_q) && $stable(rx_frames_q) && $stable(tx_fail_q)))
    else $error("counter moved without an input beat");

  a_commit_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_rep && i_last) |=> (last_time_q == {1'b0, $past(now_q)}))
    else $error("update time not taken on the last report");
`endif

endmodule

`default_nettype wire

### design/ltrf_div.sv
`default_nettype none

module ltrf_div
  import ltrf_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] acc_q;
  logic [7:0]  rem_q;
  logic [7:0]  dvs_q;
  logic        neg_q;
  logic [8:0]  trial;
  logic        ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, acc_q[31]};
  assign ge = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.dividend[31] ? 32'd0 - req_i.dividend : req_i.dividend;
      neg_q <= req_i.dividend[31];
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[30:0], ge};
      rem_q <= ge ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
    end
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quotient = neg_q ? 32'd0 - acc_q : acc_q;

endmodule

`default_nettype wire
